[rtl/core/pascal_lexer_token_scanner_assert.svh]
// assertion macros for the pascal lexer token scanner
// expects clk and rst_n in the scope of the module that uses them
`ifndef PASCAL_LEXER_TOKEN_SCANNER_ASSERT_SVH
`define PASCAL_LEXER_TOKEN_SCANNER_ASSERT_SVH
// property checked every clock outside reset
`define PLTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition in a cycle implies a consequence in the next
`define PLTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/core/plts_pkg.sv]
// shared types, constants and the lexer transition function
// no dependencies
package plts_pkg;

  localparam int MAX_TOKEN_LEN = 32;
  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam int IDX_W = $clog2(MAX_TOKEN_LEN);

  typedef enum logic [4:0] {
    K_ERROR, K_IDENT, K_INT, K_REAL, K_EXPREAL, K_HEX, K_STRING, K_CHAR,
    K_PLUS, K_MINUS, K_STAR, K_SLASH, K_EQUAL, K_SEMI, K_DOT, K_COMMA,
    K_LPAR, K_RPAR, K_GT, K_GE, K_LT, K_LE, K_NE, K_COLON, K_ASSIGN
  } kind_t;

  typedef enum logic [4:0] {
    S_START, S_IDENT, S_PAREN, S_PCOMMENT, S_PSTAR, S_GT, S_LT, S_COLON,
    S_INT, S_REAL, S_HEX, S_EXPMARK, S_EXPDIG, S_STR, S_STRQUOTE,
    S_CHARQUOTE, S_CHARBODY, S_QUOTEOPEN, S_BCOMMENT
  } scan_st_t;

  typedef enum logic [2:0] {
    C_IDLE, C_SCAN, C_FLUSH, C_RD, C_WR
  } ctl_st_t;

  typedef struct packed {
    logic take;
    logic clr;
    logic scan;
    logic flush;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic fin;
    logic rescan;
    logic full;
    logic slot_free;
    logic last;
  } dp_stat_t;

  typedef struct packed {
    scan_st_t nxt;
    logic     store;
    logic     drop;
    logic     fin;
    kind_t    kind;
    logic     rescan;
    logic     set_pend;
    kind_t    pkind;
  } scan_dec_t;

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_xdigit(logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_graph(logic [7:0] c);
    return c >= 8'h21 && c <= 8'h7E;
  endfunction

  // one step of the lexer; finish means send the buffer after store/drop
  function automatic scan_dec_t scan_decode(scan_st_t s, logic [7:0] c);
    scan_dec_t d;
    d = '0;
    d.nxt = s;
    d.kind = K_ERROR;
    d.pkind = K_ERROR;
    unique case (s)
      S_START: begin
        priority if (is_alpha(c) || c == "_") begin
          d.store = 1'b1; d.nxt = S_IDENT; d.set_pend = 1'b1; d.pkind = K_IDENT;
        end else if (is_space(c)) begin
          d.nxt = S_START;
        end else if (is_digit(c)) begin
          d.store = 1'b1; d.nxt = S_INT; d.set_pend = 1'b1; d.pkind = K_INT;
        end else begin
          d.store = 1'b1;
          d.fin = 1'b1;
          unique case (c)
            "+": d.kind = K_PLUS;
            "-": d.kind = K_MINUS;
            "*": d.kind = K_STAR;
            "/": d.kind = K_SLASH;
            "=": d.kind = K_EQUAL;
            ";": d.kind = K_SEMI;
            ".": d.kind = K_DOT;
            ",": d.kind = K_COMMA;
            ")": d.kind = K_RPAR;
            "(": begin d.fin = 1'b0; d.nxt = S_PAREN; end
            ">": begin d.fin = 1'b0; d.nxt = S_GT; end
            "<": begin d.fin = 1'b0; d.nxt = S_LT; end
            ":": begin d.fin = 1'b0; d.nxt = S_COLON; end
            "'": begin d.fin = 1'b0; d.store = 1'b0; d.nxt = S_QUOTEOPEN; end
            "{": begin d.fin = 1'b0; d.store = 1'b0; d.nxt = S_BCOMMENT; end
            "$": begin d.fin = 1'b0; d.store = 1'b0; d.nxt = S_HEX; end
            default: d.kind = K_ERROR;
          endcase
        end
      end
      S_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == "_") d.store = 1'b1;
        else begin d.fin = 1'b1; d.kind = K_IDENT; d.rescan = 1'b1; end
      end
      S_PAREN: begin
        if (c == "*") begin d.drop = 1'b1; d.nxt = S_PCOMMENT; end
        else begin d.fin = 1'b1; d.kind = K_LPAR; d.rescan = 1'b1; end
      end
      S_BCOMMENT: if (c == "}") d.nxt = S_START;
      S_PCOMMENT: if (c == "*") d.nxt = S_PSTAR;
      S_PSTAR: begin
        priority if (c == ")") d.nxt = S_START;
        else if (c != "*") d.nxt = S_PCOMMENT;
        else d.nxt = S_PSTAR;
      end
      S_GT: begin
        if (c == "=") begin d.store = 1'b1; d.fin = 1'b1; d.kind = K_GE; end
        else begin d.fin = 1'b1; d.kind = K_GT; d.rescan = 1'b1; end
      end
      S_LT: begin
        priority if (c == "=") begin d.store = 1'b1; d.fin = 1'b1; d.kind = K_LE; end
        else if (c == ">") begin d.store = 1'b1; d.fin = 1'b1; d.kind = K_NE; end
        else begin d.fin = 1'b1; d.kind = K_LT; d.rescan = 1'b1; end
      end
      S_COLON: begin
        if (c == "=") begin d.store = 1'b1; d.fin = 1'b1; d.kind = K_ASSIGN; end
        else begin d.fin = 1'b1; d.kind = K_COLON; d.rescan = 1'b1; end
      end
      S_INT: begin
        priority if (is_digit(c)) d.store = 1'b1;
        else if (c == ".") begin d.store = 1'b1; d.nxt = S_REAL; end
        else begin d.fin = 1'b1; d.kind = K_INT; d.rescan = 1'b1; end
      end
      S_HEX: begin
        if (is_xdigit(c)) d.store = 1'b1;
        else begin d.fin = 1'b1; d.kind = K_HEX; d.rescan = 1'b1; end
      end
      S_REAL: begin
        priority if (is_digit(c)) d.store = 1'b1;
        else if (c == "e" || c == "E") begin d.store = 1'b1; d.nxt = S_EXPMARK; end
        else begin d.fin = 1'b1; d.kind = K_REAL; d.rescan = 1'b1; end
      end
      S_EXPMARK: begin
        if (c == "+" || c == "-" || is_digit(c)) begin d.store = 1'b1; d.nxt = S_EXPDIG; end
        else begin d.fin = 1'b1; d.kind = K_EXPREAL; d.rescan = 1'b1; end
      end
      S_EXPDIG: begin
        if (is_digit(c)) d.store = 1'b1;
        else begin d.fin = 1'b1; d.kind = K_EXPREAL; d.rescan = 1'b1; end
      end
      S_STR: begin
        if (c == "'") d.nxt = S_STRQUOTE;
        else d.store = 1'b1;
      end
      S_STRQUOTE: begin
        if (c == "'") begin d.store = 1'b1; d.nxt = S_STR; end
        else begin d.fin = 1'b1; d.kind = K_STRING; d.rescan = 1'b1; end
      end
      S_CHARBODY: begin
        d.store = 1'b1;
        d.nxt = (c == "'") ? S_CHARQUOTE : S_STR;
      end
      S_CHARQUOTE: begin
        if (c == "'") begin d.store = 1'b1; d.nxt = S_STR; end
        else begin d.drop = 1'b1; d.fin = 1'b1; d.kind = K_CHAR; d.rescan = 1'b1; end
      end
      S_QUOTEOPEN: begin
        if (is_graph(c)) begin d.store = 1'b1; d.nxt = S_CHARBODY; end
      end
      default: begin d.nxt = S_START; d.rescan = 1'b1; end
    endcase
    return d;
  endfunction

endpackage

[rtl/core/pascal_lexer_token_scanner.sv]
// top level of the pascal lexer token scanner
// an input byte passes accept and scan steps when it ends no token; a finished token
// adds a read and a write step per value beat, a rescanned byte another scan step,
// and a full buffer a flush step; the emit loop reading the buffer memory sets the rate
// reset is synchronous active low; it clears the lexer state, not the buffer contents
// depends on plts_pkg, plts_ctrl and plts_dpath
module pascal_lexer_token_scanner import plts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // source side
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] source_byte
  input  logic        in_tlast,   // end_of_input, drops any pending token
  // token side
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] value_char, [8] char_valid, rest zero
  output logic        out_tlast,  // last_of_token
  output logic [4:0]  out_tuser   // [4:0] token_kind
);

  ctl_cmd_t   cmd;
  dp_stat_t   stat;
  logic [7:0] out_char;
  logic       out_cv;
  kind_t      out_kind;

  // controller steps through accept, scan, optional flush and the beat loop
  plts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath holds the lexer state, the token buffer and the output register
  plts_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_char   (out_char),
    .out_cv     (out_cv),
    .out_last   (out_tlast),
    .out_kind   (out_kind)
  );

  assign out_tdata = {7'b0, out_cv, out_char};
  assign out_tuser = out_kind;

endmodule

[rtl/core/plts_ctrl.sv]
// sequencer: accept, scan, flush and per-byte emit steps
// depends on plts_pkg
module plts_ctrl import plts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_tlast,
  output logic     in_tready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  ctl_st_t st_r, st_nxt;
  logic    resc_r, resc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= C_IDLE;
      resc_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      resc_r <= resc_nxt;
    end
  end

  // next state
  always_comb begin
    st_nxt   = st_r;
    resc_nxt = resc_r;
    unique case (st_r)
      C_IDLE: if (in_tvalid && !in_tlast) st_nxt = C_SCAN;
      C_SCAN: begin
        priority if (stat.fin) begin
          st_nxt   = C_RD;
          resc_nxt = stat.rescan;
        end else if (stat.full) begin
          st_nxt = C_FLUSH;
        end else begin
          st_nxt = C_IDLE;
        end
      end
      C_FLUSH: begin
        st_nxt   = C_RD;
        resc_nxt = 1'b0;
      end
      C_RD: st_nxt = C_WR;
      C_WR: begin
        if (stat.slot_free) begin
          priority if (!stat.last) st_nxt = C_RD;
          else if (resc_r) st_nxt = C_SCAN;
          else st_nxt = C_IDLE;
        end
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_tready = (st_r == C_IDLE);
    cmd.take  = (st_r == C_IDLE) && in_tvalid && !in_tlast;
    cmd.clr   = (st_r == C_IDLE) && in_tvalid && in_tlast;
    cmd.scan  = (st_r == C_SCAN);
    cmd.flush = (st_r == C_FLUSH);
    cmd.emit  = (st_r == C_WR) && stat.slot_free;
  end

endmodule

[rtl/core/plts_dpath.sv]
// datapath: lexer state, value buffer, emit counter and output register
// depends on plts_pkg and the assertion macro header
module plts_dpath import plts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  ctl_cmd_t   cmd,
  output dp_stat_t   stat,
  input  logic       out_tready,
  output logic       out_tvalid,
  output logic [7:0] out_char,
  output logic       out_cv,
  output logic       out_last,
  output kind_t      out_kind
);

  `include "pascal_lexer_token_scanner_assert.svh"

  scan_st_t         state_r;
  logic [LEN_W-1:0] len_r;
  kind_t            pend_r;
  logic [7:0]       byte_r;
  logic [7:0]       mem [MAX_TOKEN_LEN];
  logic [7:0]       rd_data_r;
  logic [IDX_W-1:0] idx_r;
  logic [LEN_W-1:0] emit_len_r;
  kind_t            emit_kind_r;
  logic             out_valid_r;
  logic [7:0]       out_char_r;
  logic             out_cv_r;
  logic             out_last_r;
  kind_t            out_kind_r;

  scan_dec_t        dec;
  logic             store_ok;
  logic             drop_ok;
  logic [LEN_W-1:0] len_upd;
  logic             last;

  always_comb begin
    dec      = scan_decode(state_r, byte_r);
    store_ok = dec.store && (len_r < LEN_W'(MAX_TOKEN_LEN));
    drop_ok  = dec.drop && (len_r != '0);
    len_upd  = len_r + LEN_W'(store_ok) - LEN_W'(drop_ok);
    last     = (emit_len_r == '0) || ((LEN_W'(idx_r) + LEN_W'(1)) == emit_len_r);
    stat.fin       = dec.fin;
    stat.rescan    = dec.rescan;
    stat.full      = !dec.fin && (len_upd == LEN_W'(MAX_TOKEN_LEN));
    stat.slot_free = !out_valid_r || out_tready;
    stat.last      = last;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_START;
      len_r       <= '0;
      pend_r      <= K_ERROR;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr || cmd.flush || (cmd.scan && dec.fin)) begin
        state_r <= S_START;
        len_r   <= '0;
        pend_r  <= K_ERROR;
      end else if (cmd.scan) begin
        state_r <= dec.nxt;
        len_r   <= len_upd;
        if (dec.set_pend) pend_r <= dec.pkind;
      end
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // buffer memory, registered read at the emit index
  always_ff @(posedge clk) begin
    if (cmd.scan && store_ok) mem[len_r[IDX_W-1:0]] <= byte_r;
    rd_data_r <= mem[idx_r];
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.take) byte_r <= in_byte;
    if (cmd.scan && dec.fin) begin
      emit_kind_r <= dec.kind;
      emit_len_r  <= len_upd;
      idx_r       <= '0;
    end else if (cmd.flush) begin
      emit_kind_r <= pend_r;
      emit_len_r  <= len_r;
      idx_r       <= '0;
    end else if (cmd.emit) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    if (cmd.emit) begin
      out_kind_r <= emit_kind_r;
      out_cv_r   <= (emit_len_r != '0);
      out_char_r <= (emit_len_r != '0) ? rd_data_r : 8'h00;
      out_last_r <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_char   = out_char_r;
  assign out_cv     = out_cv_r;
  assign out_last   = out_last_r;
  assign out_kind   = out_kind_r;

  `PLTS_ASSERT(a_len_bound, (len_r <= LEN_W'(MAX_TOKEN_LEN)), "buffer length past limit")
  `PLTS_ASSERT(a_start_empty, ((state_r == S_START) |-> (len_r == '0)), "start state with data")
  `PLTS_ASSERT(a_flush_full, (cmd.flush |-> (len_r == LEN_W'(MAX_TOKEN_LEN))), "flush not full")
  `PLTS_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid_r, "emitted beat not shown")

endmodule
